// ----- rtl/dft_pkg.sv -----
`default_nettype none

package dft_pkg;

   // character codes
   localparam logic [7:0] QUOTE_CHAR     = 8'h22;
   localparam logic [7:0] SPACE_CHAR     = 8'h20;
   localparam logic [7:0] CR_CHAR        = 8'h0D;
   localparam logic [7:0] LF_CHAR        = 8'h0A;

   // register map
   localparam logic       REG_DELIMITER  = 1'b0;
   localparam logic [7:0] DELIMITER_RESET = 8'd44;

   // parser mode
   typedef enum logic [3:0] {
      MODE_SEEK       = 4'b0001,
      MODE_PLAIN      = 4'b0010,
      MODE_QUOTED     = 4'b0100,
      MODE_QUOTE_SEEN = 4'b1000
   } mode_type;

   // result sequencer phase
   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_FLUSH  = 5'b00010,
      PH_SLOT_A = 5'b00100,
      PH_SLOT_B = 5'b01000,
      PH_SLOT_C = 5'b10000
   } phase_type;

   // one result, packed with out_byte in the lowest bits
   typedef struct packed {
      logic       pending_overflow;
      logic       text_end;
      logic       field_end;
      logic       has_byte;
      logic [7:0] out_byte;
   } res_type;

   // controller to datapath
   typedef struct packed {
      logic      load;
      logic      emit;
      logic      last;
      phase_type phase;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic nxt_flush;
      logic nxt_a;
      logic nxt_b;
      logic nxt_c;
      logic cur_flush;
      logic cur_a;
      logic cur_b;
      logic cur_c;
      logic flush_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/dft_controller.sv -----
`default_nettype none

module dft_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire dft_pkg::stat_type stat,
   output dft_pkg::cmd_type       cmd
);
   import dft_pkg::*;

   phase_type state_ff;
   phase_type state_in;
   phase_type after;
   phase_type start;
   logic      load;
   logic      emit;

   // phase that follows the current one
   always_comb begin
      case (state_ff)
         PH_FLUSH: begin
            if (!stat.flush_last) after = PH_FLUSH;
            else if (stat.cur_a)  after = PH_SLOT_A;
            else if (stat.cur_b)  after = PH_SLOT_B;
            else if (stat.cur_c)  after = PH_SLOT_C;
            else                  after = PH_IDLE;
         end
         PH_SLOT_A: begin
            if (stat.cur_b)      after = PH_SLOT_B;
            else if (stat.cur_c) after = PH_SLOT_C;
            else                 after = PH_IDLE;
         end
         PH_SLOT_B: begin
            if (stat.cur_c) after = PH_SLOT_C;
            else            after = PH_IDLE;
         end
         default: after = PH_IDLE;
      endcase
   end

   // first phase of a freshly accepted byte
   always_comb begin
      if (stat.nxt_flush)  start = PH_FLUSH;
      else if (stat.nxt_a) start = PH_SLOT_A;
      else if (stat.nxt_b) start = PH_SLOT_B;
      else if (stat.nxt_c) start = PH_SLOT_C;
      else                 start = PH_IDLE;
   end

   assign req_tready = (state_ff == PH_IDLE);
   assign load       = req_tvalid && req_tready;
   assign emit       = (state_ff != PH_IDLE) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      if (load)      state_in = start;
      else if (emit) state_in = after;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= PH_IDLE;
      else       state_ff <= state_in;
   end

   assign cmd.load  = load;
   assign cmd.emit  = emit;
   assign cmd.last  = (after == PH_IDLE);
   assign cmd.phase = state_ff;

   // the final result of a byte returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && cmd.last) |=> (state_ff == PH_IDLE))
      else $error("sequencer not idle after last result");

   // flush phase only when a flush was planned
   a_flush_plan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_FLUSH) |-> stat.cur_flush)
      else $error("flush phase without planned flush");

   // a byte is taken only when nothing of the previous one is left to emit
   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      load |-> !emit)
      else $error("load while results still pending");

endmodule

`default_nettype wire

// ----- rtl/dft_datapath.sv -----
`default_nettype none

module dft_datapath #(
   parameter int HELD_SPACE_DEPTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        delimiter,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   input  wire dft_pkg::cmd_type  cmd,
   output dft_pkg::stat_type      stat,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,
   output logic                   rsp_tlast
);
   import dft_pkg::*;

   localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);
   localparam int IW = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

   // parser state
   mode_type        mode_ff, mode_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            fhc_ff, fhc_in;

   // plan of the byte being emitted
   logic [CW-1:0]   flush_len_ff, flush_len_in;
   logic            a_vld_ff, b_vld_ff, c_vld_ff;
   logic            a_vld_in, b_vld_in, c_vld_in;
   res_type         a_res_ff, b_res_ff, c_res_ff;
   res_type         a_res_in, b_res_in, c_res_in;

   // held whitespace store
   logic [7:0]      held_mem [HELD_SPACE_DEPTH];
   logic [7:0]      rd_ff;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]   rd_addr;
   logic            hold_wr;

   // output register
   logic            out_vld_ff;
   res_type         out_ff;
   logic            out_last_ff;
   res_type         res_sel;

   // seek outcome
   mode_type        sk_mode;
   logic            sk_fhc;
   logic [CW-1:0]   sk_cnt;
   logic            sk_vld;

   logic [7:0]      c;
   logic            is_space;
   logic            is_quote;
   logic            is_delim;
   res_type         byte_res;
   res_type         fe_res;
   res_type         ov_res;

   assign c        = req_tdata;
   assign is_space = (c == SPACE_CHAR) || (c == CR_CHAR) || (c == LF_CHAR);
   assign is_quote = (c == QUOTE_CHAR);
   assign is_delim = (c == delimiter);

   always_comb begin
      byte_res          = '0;
      byte_res.has_byte = 1'b1;
      byte_res.out_byte = c;
      fe_res            = '0;
      fe_res.field_end  = 1'b1;
      ov_res            = '0;
      ov_res.pending_overflow = 1'b1;
   end

   // what a byte does between fields
   always_comb begin
      sk_mode = MODE_SEEK;
      sk_fhc  = fhc_ff;
      sk_cnt  = cnt_ff;
      sk_vld  = 1'b0;
      if (is_delim) begin
         sk_mode = MODE_PLAIN;
         sk_fhc  = 1'b0;
         sk_cnt  = '0;
      end else if (is_space) begin
         sk_mode = MODE_SEEK;
      end else if (is_quote) begin
         sk_mode = MODE_QUOTED;
      end else begin
         sk_mode = MODE_PLAIN;
         sk_fhc  = 1'b1;
         sk_cnt  = '0;
         sk_vld  = 1'b1;
      end
   end

   // plan for the incoming byte and next parser state
   always_comb begin
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      fhc_in       = fhc_ff;
      hold_wr      = 1'b0;
      flush_len_in = '0;
      a_vld_in     = 1'b0;
      a_res_in     = byte_res;
      b_vld_in     = 1'b0;
      b_res_in     = byte_res;
      case (mode_ff)
         MODE_PLAIN: begin
            if (is_quote) begin
               cnt_in  = '0;
               mode_in = MODE_QUOTED;
            end else if (is_delim) begin
               a_vld_in = 1'b1;
               a_res_in = fe_res;
               cnt_in   = '0;
               fhc_in   = 1'b0;
            end else if (is_space) begin
               if (fhc_ff) begin
                  if (cnt_ff < CW'(HELD_SPACE_DEPTH)) begin
                     hold_wr = 1'b1;
                     cnt_in  = cnt_ff + CW'(1);
                  end else begin
                     a_vld_in = 1'b1;
                     a_res_in = ov_res;
                  end
               end
            end else begin
               flush_len_in = cnt_ff;
               cnt_in       = '0;
               fhc_in       = 1'b1;
               a_vld_in     = 1'b1;
            end
         end
         MODE_QUOTED: begin
            if (is_quote) mode_in = MODE_QUOTE_SEEN;
            else          a_vld_in = 1'b1;
         end
         MODE_QUOTE_SEEN: begin
            if (is_quote) begin
               a_vld_in = 1'b1;
               mode_in  = MODE_QUOTED;
            end else begin
               a_vld_in = 1'b1;
               a_res_in = fe_res;
               mode_in  = sk_mode;
               fhc_in   = sk_fhc;
               cnt_in   = sk_cnt;
               b_vld_in = sk_vld;
            end
         end
         default: begin
            mode_in  = sk_mode;
            fhc_in   = sk_fhc;
            cnt_in   = sk_cnt;
            a_vld_in = sk_vld;
         end
      endcase
      // end of text mark, with a field end unless between fields
      c_vld_in           = req_tlast;
      c_res_in           = '0;
      c_res_in.text_end  = 1'b1;
      c_res_in.field_end = (mode_in != MODE_SEEK);
      if (req_tlast) begin
         mode_in = MODE_SEEK;
         cnt_in  = '0;
         fhc_in  = 1'b0;
      end
   end

   // parser state and plan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SEEK;
         cnt_ff       <= '0;
         fhc_ff       <= 1'b0;
         flush_len_ff <= '0;
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
      end else if (cmd.load) begin
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         fhc_ff       <= fhc_in;
         flush_len_ff <= flush_len_in;
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         c_vld_ff     <= c_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_res_ff <= a_res_in;
         b_res_ff <= b_res_in;
         c_res_ff <= c_res_in;
      end
   end

   // flush index, read address runs one ahead on each flushed byte
   always_comb begin
      idx_in  = idx_ff;
      rd_addr = idx_ff;
      if (cmd.load) begin
         idx_in  = '0;
         rd_addr = '0;
      end else if (cmd.emit && (cmd.phase == PH_FLUSH)) begin
         idx_in  = idx_ff + IW'(1);
         rd_addr = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else       idx_ff <= idx_in;
   end

   // held whitespace memory
   always_ff @(posedge clock) begin
      if (cmd.load && hold_wr) held_mem[cnt_ff[IW-1:0]] <= c;
      rd_ff <= held_mem[rd_addr];
   end

   // result selection
   always_comb begin
      case (cmd.phase)
         PH_FLUSH: begin
            res_sel          = '0;
            res_sel.has_byte = 1'b1;
            res_sel.out_byte = rd_ff;
         end
         PH_SLOT_A: res_sel = a_res_ff;
         PH_SLOT_B: res_sel = b_res_ff;
         PH_SLOT_C: res_sel = c_res_ff;
         default:   res_sel = '0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_ff      <= res_sel;
         out_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0000, out_ff};
   assign rsp_tlast  = out_last_ff;

   // status to the controller
   assign stat.nxt_flush  = (flush_len_in != '0);
   assign stat.nxt_a      = a_vld_in;
   assign stat.nxt_b      = b_vld_in;
   assign stat.nxt_c      = c_vld_in;
   assign stat.cur_flush  = (flush_len_ff != '0);
   assign stat.cur_a      = a_vld_ff;
   assign stat.cur_b      = b_vld_ff;
   assign stat.cur_c      = c_vld_ff;
   assign stat.flush_last = ((CW'(idx_ff) + CW'(1)) == flush_len_ff);
   assign stat.out_free   = !out_vld_ff || rsp_tready;

   // held count stays within the store
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HELD_SPACE_DEPTH))
      else $error("held whitespace count beyond depth");

   // whitespace is held only inside an unquoted field with content
   a_cnt_mode: assert property (@(posedge clock) disable iff (reset)
      ((mode_ff != MODE_PLAIN) || !fhc_ff) |-> (cnt_ff == '0))
      else $error("held whitespace outside an unquoted field");

   // a flushed byte always comes with its trailing content byte
   a_flush_a: assert property (@(posedge clock) disable iff (reset)
      (cmd.phase == PH_FLUSH) |-> a_vld_ff)
      else $error("flush without content byte");

endmodule

`default_nettype wire

// ----- rtl/delimited_field_tokenizer_unit.sv -----
`default_nettype none

// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: in_byte ; tlast: text_last
// rsp     | out | rsp_tvalid/tready    | tdata: out_byte, has_byte, field_end,
//         |     |                      |   text_end, pending_overflow ; tlast: run_last
// csr     | in  | psel/penable/pready  | delimiter_char at byte address 0
//
// a byte is taken while the sequencer is idle; its n results then leave one per cycle,
// while rsp does not stall, from the result sequencer through a single output register,
// and the input is held until the last result enters the output register; a byte with none does not hold it
// up to HELD_SPACE_DEPTH + 2 results per byte (held whitespace flush dominates)
// synchronous active-high reset returns the parser to the start of text
// a stall on rsp holds the sequencer; the next byte is taken while the last
// result of the previous one still waits in the output register

module delimited_field_tokenizer_unit #(
   parameter int HELD_SPACE_DEPTH = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [8] has_byte, [9] field_end,
                                         // [10] text_end, [11] pending_overflow
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import dft_pkg::*;

   logic [7:0] delimiter_ff;
   logic       csr_wr;
   cmd_type    cmd;
   stat_type   stat;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIMITER_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_DELIMITER)) begin
         delimiter_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_DELIMITER) ? {24'b0, delimiter_ff} : 32'b0;

   dft_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dft_datapath #(
      .HELD_SPACE_DEPTH (HELD_SPACE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .delimiter  (delimiter_ff),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- sim/tb_delimited_field_tokenizer_unit.sv -----
module tb_delimited_field_tokenizer_unit;
   import dft_pkg::*;

   localparam int HELD_DEPTH    = 8;
   localparam int SETTLE_CYCLES = HELD_DEPTH + 8;
   localparam int PHASE_BYTES   = 51;
   localparam int RUN_LIMIT     = 1_000_000;

   typedef struct {
      logic [7:0] value;
      logic       last;
      logic       wait_idle;
   } text_byte_type;

   typedef struct {
      res_type res;
      logic    run_last;
   } token_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   delimited_field_tokenizer_unit #(
      .HELD_SPACE_DEPTH(HELD_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] in_byte
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte, [8] has_byte, [9] field_end,
                                 // [10] text_end, [11] pending_overflow
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // tokenizer state as seen by the checker
   mode_type   tok_mode;
   logic [7:0] tok_delim;
   logic [7:0] held_spaces [HELD_DEPTH];
   int         held_count;
   logic       field_started;

   token_type     step_tokens [$];
   token_type     predicted_tokens [$];
   text_byte_type text_bytes [$];

   logic req_fire    = 1'b0;
   int   error_count = 0;
   int   burst_left  = 0;
   int   gap_left    = 0;
   int   stall_style = 0;
   int   style_left  = 0;
   int   stall_left  = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic is_blank(logic [7:0] c);
      return c == SPACE_CHAR || c == CR_CHAR || c == LF_CHAR;
   endfunction

   function void emit_token(logic [7:0] c, logic has, logic fe, logic te, logic ov);
      token_type t;
      t.res.out_byte         = has ? c : 8'h00;
      t.res.has_byte         = has;
      t.res.field_end        = fe;
      t.res.text_end         = te;
      t.res.pending_overflow = ov;
      t.run_last             = 1'b0;
      step_tokens.push_back(t);
   endfunction

   // between fields: delimiter wins over whitespace and quote
   function void seek_step(logic [7:0] c);
      if (c == tok_delim) begin
         tok_mode      = MODE_PLAIN;
         field_started = 1'b0;
         held_count    = 0;
      end else if (!is_blank(c)) begin
         if (c == QUOTE_CHAR) begin
            tok_mode = MODE_QUOTED;
         end else begin
            tok_mode      = MODE_PLAIN;
            field_started = 1'b1;
            held_count    = 0;
            emit_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
         end
      end
   endfunction

   // unquoted field: quote wins over delimiter and whitespace
   function void plain_step(logic [7:0] c);
      if (c == QUOTE_CHAR) begin
         held_count = 0;
         tok_mode   = MODE_QUOTED;
      end else if (c == tok_delim) begin
         emit_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
         held_count    = 0;
         field_started = 1'b0;
      end else if (is_blank(c)) begin
         if (field_started) begin
            if (held_count < HELD_DEPTH) begin
               held_spaces[held_count] = c;
               held_count++;
            end else begin
               emit_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
            end
         end
      end else begin
         for (int i = 0; i < held_count; i++)
            emit_token(held_spaces[i], 1'b1, 1'b0, 1'b0, 1'b0);
         held_count    = 0;
         field_started = 1'b1;
         emit_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
      end
   endfunction

   // tokens caused by one text byte, appended to the predicted stream
   function void tokenize_byte(logic [7:0] c, logic last);
      step_tokens.delete();
      case (tok_mode)
         MODE_PLAIN: plain_step(c);
         MODE_QUOTED: begin
            if (c == QUOTE_CHAR) tok_mode = MODE_QUOTE_SEEN;
            else emit_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
         end
         MODE_QUOTE_SEEN: begin
            if (c == QUOTE_CHAR) begin
               emit_token(QUOTE_CHAR, 1'b1, 1'b0, 1'b0, 1'b0);
               tok_mode = MODE_QUOTED;
            end else begin
               emit_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
               tok_mode = MODE_SEEK;
               seek_step(c);
            end
         end
         default: begin
            tok_mode = MODE_SEEK;
            seek_step(c);
         end
      endcase
      if (last) begin
         emit_token(8'h00, 1'b0, tok_mode != MODE_SEEK, 1'b1, 1'b0);
         tok_mode      = MODE_SEEK;
         held_count    = 0;
         field_started = 1'b0;
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_last = 1'b1;
      foreach (step_tokens[i]) predicted_tokens.push_back(step_tokens[i]);
   endfunction

   // monitor: register writes, accepted bytes and result checks
   always @(posedge clock) begin
      token_type want;
      logic      bad;
      req_fire = !reset && req_tvalid && req_tready;
      if (reset) begin
         tok_mode      = MODE_SEEK;
         tok_delim     = DELIMITER_RESET;
         held_count    = 0;
         field_started = 1'b0;
         predicted_tokens.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == {REG_DELIMITER, 2'b00})
            tok_delim = csr_pwdata[7:0];
         if (req_fire) tokenize_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_tokens.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result tdata=%h tlast=%b",
                           $time, rsp_tdata, rsp_tlast);
            end else begin
               want = predicted_tokens.pop_front();
               bad  = rsp_tdata[7:0]   !== want.res.out_byte ||
                      rsp_tdata[8]     !== want.res.has_byte ||
                      rsp_tdata[9]     !== want.res.field_end ||
                      rsp_tdata[10]    !== want.res.text_end ||
                      rsp_tdata[11]    !== want.res.pending_overflow ||
                      rsp_tdata[15:12] !== 4'h0 ||
                      rsp_tlast        !== want.run_last;
               if (bad) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"%0t: mismatch expected byte=%h has=%b fe=%b te=%b ov=%b ",
                               "last=%b, got tdata=%h tlast=%b"},
                              $time, want.res.out_byte, want.res.has_byte,
                              want.res.field_end, want.res.text_end,
                              want.res.pending_overflow, want.run_last,
                              rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   // sender: bursts of transactions with random gaps
   always @(negedge clock) begin
      logic          present;
      text_byte_type head;
      present = req_tvalid;
      if (req_fire) begin
         head    = text_bytes.pop_front();
         present = 1'b0;
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
      if (!present) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (text_bytes.size() > 0 &&
                      !(text_bytes[0].wait_idle && predicted_tokens.size() != 0)) begin
            present = 1'b1;
         end
      end
      if (present) begin
         head = text_bytes[0];
         req_tdata <= head.value;
         req_tlast <= head.last;
      end
      req_tvalid <= present;
   end

   // receiver: switches between always ready, random stalls and long stall runs
   always @(negedge clock) begin
      logic ready;
      ready = rsp_tready;
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 2);
         style_left  = $urandom_range(40, 200);
      end else begin
         style_left--;
      end
      case (stall_style)
         0: ready = 1'b1;
         1: ready = ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left == 0) begin
               ready      = !rsp_tready;
               stall_left = ready ? $urandom_range(1, 6) : $urandom_range(1, 8);
            end else begin
               stall_left--;
            end
         end
      endcase
      rsp_tready <= ready;
   end

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0: return SPACE_CHAR;
         1: return CR_CHAR;
         default: return LF_CHAR;
      endcase
   endfunction

   // any byte that is neither delimiter, quote nor whitespace
   function automatic logic [7:0] plain_char(logic [7:0] delim);
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == delim || c == QUOTE_CHAR || is_blank(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic logic [7:0] noise_char(logic [7:0] delim);
      case ($urandom_range(0, 5))
         0: return delim;
         1: return pick_blank();
         2: return QUOTE_CHAR;
         3: return plain_char(delim);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function void add_text_byte(logic [7:0] value, logic last, logic wait_idle);
      text_byte_type t;
      t.value     = value;
      t.last      = last;
      t.wait_idle = wait_idle;
      text_bytes.push_back(t);
   endfunction

   function void queue_string(string s, logic wait_first);
      for (int i = 0; i < s.len(); i++)
         add_text_byte(s[i], i == s.len() - 1, wait_first && i == 0);
   endfunction

   // one text: mostly well-formed fields with random content, some noise
   task automatic add_random_text(input logic [7:0] delim, output int length);
      logic [7:0] txt [$];
      int         fields;
      int         n;
      logic       waits;
      fields = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) txt.push_back(noise_char(delim));
      end else begin
         if ($urandom_range(0, 7) == 0) txt.push_back(delim);
         for (int f = 0; f < fields; f++) begin
            repeat ($urandom_range(0, 2)) txt.push_back(pick_blank());
            case ($urandom_range(0, 3))
               0, 1: begin
                  // unquoted, sometimes with a whitespace run longer than the hold buffer
                  repeat ($urandom_range(0, 5))
                     txt.push_back($urandom_range(0, 4) == 0 ? pick_blank() : plain_char(delim));
                  n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 2);
                  repeat (n) txt.push_back(pick_blank());
                  if ($urandom_range(0, 1) == 0) txt.push_back(plain_char(delim));
               end
               2: begin
                  // quoted, possibly left open on the last field
                  txt.push_back(QUOTE_CHAR);
                  n = $urandom_range(0, 5);
                  for (int k = 0; k < n; k++) begin
                     case ($urandom_range(0, 4))
                        0: txt.push_back(delim);
                        1: txt.push_back(pick_blank());
                        2: begin
                           txt.push_back(QUOTE_CHAR);
                           txt.push_back(QUOTE_CHAR);
                        end
                        default: txt.push_back(plain_char(delim));
                     endcase
                  end
                  if (f != fields - 1 || $urandom_range(0, 3) != 0) txt.push_back(QUOTE_CHAR);
                  repeat ($urandom_range(0, 2)) txt.push_back(pick_blank());
               end
               default: begin
                  // quote opened in the middle of an unquoted field
                  txt.push_back(plain_char(delim));
                  if ($urandom_range(0, 1) == 0) txt.push_back(pick_blank());
                  txt.push_back(QUOTE_CHAR);
                  txt.push_back(plain_char(delim));
                  txt.push_back(QUOTE_CHAR);
               end
            endcase
            if (f != fields - 1) txt.push_back(delim);
         end
         if ($urandom_range(0, 5) == 0) txt.push_back(delim);
      end
      if (txt.size() == 0) txt.push_back(plain_char(delim));
      waits = ($urandom_range(0, 9) == 0);
      foreach (txt[i]) add_text_byte(txt[i], i == txt.size() - 1, waits && i == 0);
      length = txt.size();
   endtask

   task automatic write_delimiter(input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_DELIMITER, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_until_idle();
      while (text_bytes.size() != 0 || predicted_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      logic [7:0] delim_plan [7] = '{8'h00, 8'hFF, SPACE_CHAR, QUOTE_CHAR, 8'h3B, 8'h09,
                                     DELIMITER_RESET};
      int         added;
      int         length;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // leading delimiter, doubled quote, delimiter after a closed quoted field
      queue_string(",\"a\"\"b\" ,c", 1'b0);
      // quote inside an unquoted field, closing quote on the last byte
      queue_string("d \"e\"", 1'b0);
      // open quoted field at text end, sent only once the block is drained
      queue_string("\"f", 1'b1);
      // whitespace only
      add_text_byte(CR_CHAR, 1'b0, 1'b0);
      add_text_byte(LF_CHAR, 1'b0, 1'b0);
      add_text_byte(SPACE_CHAR, 1'b1, 1'b0);
      // byte extremes, text ending right after a delimiter
      add_text_byte(8'hFF, 1'b0, 1'b0);
      add_text_byte(8'h00, 1'b0, 1'b0);
      add_text_byte(DELIMITER_RESET, 1'b1, 1'b0);
      add_text_byte(DELIMITER_RESET, 1'b1, 1'b0);
      wait_until_idle();

      // random texts under each delimiter setting
      foreach (delim_plan[p]) begin
         write_delimiter(delim_plan[p]);
         added = 0;
         while (added < PHASE_BYTES) begin
            add_random_text(delim_plan[p], length);
            added += length;
         end
         wait_until_idle();
      end

      if (error_count == 0 && predicted_tokens.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
